FILE: rtl/nrmc_pkg.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed parser package
// Shared types, character codes and arithmetic constants.
// ---------------------------------------------------------------------------
package nrmc_pkg;

    // Characters recognized in the sentence text.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [15:0] CHARS_RM  = 16'h524D;

    // Comma positions of the status and speed fields.
    localparam logic [3:0] COMMA_STATUS = 4'd2;
    localparam logic [3:0] COMMA_SPEED  = 4'd7;
    localparam logic [3:0] COMMA_MAX    = 4'd8;

    // Speed field parse phases.
    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_INT  = 2'd1;
    localparam logic [1:0] PHASE_FRAC = 2'd2;
    localparam logic [1:0] PHASE_DONE = 2'd3;

    // Report kinds.
    localparam logic KIND_SPEED  = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_ZERO   = 2'd2;

    // Configuration reset values.
    localparam logic [19:0] GAIN_RESET   = 20'd127441;
    localparam logic [15:0] OFFSET_RESET = 16'd1200;
    localparam logic [15:0] ZERO_RESET   = 16'd1500;

    // Arithmetic constants.
    localparam logic [23:0] KNOTS_MAX   = 24'hFFFFFF;
    localparam logic [44:0] ROUND_Q16   = 45'd32768;
    localparam logic [30:0] HALF_KMH    = 31'd500;
    // ceil(2^39 / 1000): exact quotient for dividends below 2^30.
    localparam logic [29:0] RECIP_1000  = 30'd549755814;
    localparam int          RECIP_SHIFT = 39;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 4;

    // One report request from the front to the back.
    typedef struct packed {
        logic        kind;
        logic [23:0] knots_milli;
    } req_t;

    // Calibration settings seen by the back.
    typedef struct packed {
        logic [19:0] gain_q16;
        logic [15:0] offset_milli_kmh;
        logic [15:0] zero_below_milli_kmh;
    } cfg_t;

endpackage

FILE: rtl/nmea_rmc_speed_parser.sv
// ---------------------------------------------------------------------------
// NMEA RMC speed parser
// Parses RMC sentences a byte at a time and reports calibrated speed.
// ---------------------------------------------------------------------------
// Throughput: one byte accepted per clock cycle while the request queue has room.
// A reporting newline's result passes through the request queue, stages s1 to s3 and the result register.
// The back end is a four-stage pipeline around a 24x20 gain multiplier and a 30x30 reciprocal multiplier.
// Reset clears all sentence state and loads the calibration reset values.
module nmea_rmc_speed_parser import nrmc_pkg::*; #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        report_kind,
    output logic [15:0] speed_kmh,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    cfg_t cfg_reg;
    logic byte_valid;
    logic req_valid;
    req_t front_req;
    req_t queue_req;
    logic q_full;
    logic q_empty;
    logic req_take;

    assign full       = q_full;
    assign byte_valid = push && !q_full;
    assign cfg_ready  = 1'b1;

    // Calibration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_q16             <= GAIN_RESET;
            cfg_reg.offset_milli_kmh     <= OFFSET_RESET;
            cfg_reg.zero_below_milli_kmh <= ZERO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAIN:   cfg_reg.gain_q16             <= cfg_data;
                REG_OFFSET: cfg_reg.offset_milli_kmh     <= cfg_data[15:0];
                REG_ZERO:   cfg_reg.zero_below_milli_kmh <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    nrmc_front #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .rx_byte   (rx_byte),
        .req_valid (req_valid),
        .req       (front_req)
    );

    nrmc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (req_valid),
        .wr_data(front_req),
        .full   (q_full),
        .rd_en  (req_take),
        .rd_data(queue_req),
        .empty  (q_empty)
    );

    nrmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .req_avail  (!q_empty),
        .req        (queue_req),
        .req_take   (req_take),
        .empty      (empty),
        .pop        (pop),
        .report_kind(report_kind),
        .speed_kmh  (speed_kmh)
    );

endmodule

FILE: rtl/nrmc_front.sv
// ---------------------------------------------------------------------------
// NMEA RMC front end
// Tracks one sentence a byte per cycle and emits a report request on a
// stored newline once "RMC" has been seen.
// ---------------------------------------------------------------------------
module nrmc_front import nrmc_pkg::*; #(
    parameter int BUFFER_BYTES = 128
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       req_valid,
    output req_t       req
);

    localparam int CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] COUNT_LIMIT = CW'(BUFFER_BYTES - 1);

    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    comma_reg, comma_next;
    logic [15:0]   recent_reg, recent_next;
    logic          rmc_reg, rmc_next;
    logic          stat_next_reg, stat_next_next;
    logic          stat_ok_reg, stat_ok_next;
    logic [1:0]    phase_reg, phase_next;
    logic [23:0]   knots_reg, knots_next;
    logic [1:0]    frac_reg, frac_next;
    logic          ended_reg, ended_next;

    logic          restart;
    logic          digit;
    logic [3:0]    dval;
    logic [27:0]   int_sum;
    logic [24:0]   frac_sum;
    logic [9:0]    frac_w;
    logic [3:0]    comma_inc;

    // Character classification and digit arithmetic.
    always_comb
    begin
        restart  = (rx_byte == CHAR_DOLLAR);
        digit    = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
        dval     = digit ? rx_byte[3:0] : 4'd0;
        int_sum  = {1'b0, knots_reg, 3'b000} + {3'b000, knots_reg, 1'b0}
                 + (28'(dval) * 28'd1000);
        case (frac_reg)
            2'd0:    frac_w = 10'd100;
            2'd1:    frac_w = 10'd10;
            default: frac_w = 10'd1;
        endcase
        frac_sum  = {1'b0, knots_reg} + 25'(dval * frac_w);
        comma_inc = comma_reg + 4'd1;
    end

    // Next sentence state for an accepted byte.
    always_comb
    begin
        count_next     = count_reg;
        comma_next     = comma_reg;
        recent_next    = recent_reg;
        rmc_next       = rmc_reg;
        stat_next_next = stat_next_reg;
        stat_ok_next   = stat_ok_reg;
        phase_next     = phase_reg;
        knots_next     = knots_reg;
        frac_next      = frac_reg;
        ended_next     = ended_reg;
        req_valid      = 1'b0;

        if (byte_valid)
        begin
            if (restart)
            begin
                // A dollar sign opens a new sentence and is then stored.
                count_next     = CW'(1);
                comma_next     = 4'd0;
                recent_next    = {8'h00, rx_byte};
                rmc_next       = 1'b0;
                stat_next_next = 1'b0;
                stat_ok_next   = 1'b0;
                phase_next     = PHASE_IDLE;
                knots_next     = 24'd0;
                frac_next      = 2'd0;
                ended_next     = 1'b0;
            end
            else if (count_reg != COUNT_LIMIT)
            begin
                count_next = count_reg + CW'(1);
                if (!ended_reg)
                begin
                    if (stat_next_reg)
                    begin
                        stat_ok_next   = (rx_byte == CHAR_A);
                        stat_next_next = 1'b0;
                    end

                    case (phase_reg)
                        PHASE_INT:
                        begin
                            if (digit)
                                knots_next = (int_sum > 28'(KNOTS_MAX)) ?
                                             KNOTS_MAX : int_sum[23:0];
                            else if (rx_byte == CHAR_DOT)
                                phase_next = PHASE_FRAC;
                            else
                                phase_next = PHASE_DONE;
                        end
                        PHASE_FRAC:
                        begin
                            if (digit)
                            begin
                                if (frac_reg != 2'd3)
                                begin
                                    knots_next = frac_sum[24] ? KNOTS_MAX : frac_sum[23:0];
                                    frac_next  = frac_reg + 2'd1;
                                end
                            end
                            else
                                phase_next = PHASE_DONE;
                        end
                        default:
                        begin
                        end
                    endcase

                    if ((rx_byte == CHAR_COMMA) && (comma_reg < COMMA_MAX))
                    begin
                        comma_next = comma_inc;
                        if (comma_inc == COMMA_STATUS)
                            stat_next_next = 1'b1;
                        if (comma_inc == COMMA_SPEED)
                            phase_next = PHASE_INT;
                    end

                    if ((recent_reg == CHARS_RM) && (rx_byte == CHAR_C))
                        rmc_next = 1'b1;
                    recent_next = {recent_reg[7:0], rx_byte};

                    if (rx_byte == CHAR_NUL)
                        ended_next = 1'b1;
                end

                // A stored newline reports on the text so far.
                req_valid = (rx_byte == CHAR_NL) && rmc_next;
            end
        end

        req.kind        = stat_ok_next ? KIND_SPEED : KIND_SEARCH;
        req.knots_milli = knots_next;
    end

    // Sentence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            comma_reg     <= 4'd0;
            recent_reg    <= 16'd0;
            rmc_reg       <= 1'b0;
            stat_next_reg <= 1'b0;
            stat_ok_reg   <= 1'b0;
            phase_reg     <= PHASE_IDLE;
            knots_reg     <= 24'd0;
            frac_reg      <= 2'd0;
            ended_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            comma_reg     <= comma_next;
            recent_reg    <= recent_next;
            rmc_reg       <= rmc_next;
            stat_next_reg <= stat_next_next;
            stat_ok_reg   <= stat_ok_next;
            phase_reg     <= phase_next;
            knots_reg     <= knots_next;
            frac_reg      <= frac_next;
            ended_reg     <= ended_next;
        end
    end

    // The stored count never passes the buffer limit.
    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_LIMIT)
        else $error("stored count exceeds buffer limit");

    // The comma count saturates at eight.
    a_comma_limit: assert property (@(posedge clk) disable iff (!rst_n)
        comma_reg <= COMMA_MAX)
        else $error("comma count exceeds saturation value");

endmodule

FILE: rtl/nrmc_queue.sv
// ---------------------------------------------------------------------------
// NMEA RMC request queue
// Short queue of report requests between the front and the back.
// ---------------------------------------------------------------------------
module nrmc_queue import nrmc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  req_t wr_data,
    output logic full,
    input  logic rd_en,
    output req_t rd_data,
    output logic empty
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    req_t          mem [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   level_reg, level_next;

    assign full    = (level_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty   = (level_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    // Occupancy follows the write and read transactions.
    always_comb
    begin
        level_next = level_reg;
        case ({wr_en, rd_en})
            2'b10:   level_next = level_reg + (PW+1)'(1);
            2'b01:   level_next = level_reg - (PW+1)'(1);
            default: level_next = level_reg;
        endcase
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (rd_en)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            level_reg <= level_next;
        end
    end

    // The queue is never written while full nor read while empty.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full) && !(rd_en && empty))
        else $error("queue overflow or underflow");

endmodule

FILE: rtl/nrmc_back.sv
// ---------------------------------------------------------------------------
// NMEA RMC calibration back end
// Pipelined knots to km/h conversion with threshold, rounding and
// saturation, ending in the result register.
// ---------------------------------------------------------------------------
module nrmc_back import nrmc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        req_avail,
    input  req_t        req,
    output logic        req_take,
    output logic        empty,
    input  logic        pop,
    output logic        report_kind,
    output logic [15:0] speed_kmh
);

    logic        advance;

    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [43:0] s1_prod_reg;

    logic        s2_valid_reg;
    logic        s2_kind_reg;
    logic        s2_zero_reg;
    logic [29:0] s2_x_reg;

    logic        s3_valid_reg;
    logic        s3_kind_reg;
    logic        s3_zero_reg;
    logic [20:0] s3_quot_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [15:0] out_speed_reg;

    logic [44:0] rounded;
    logic [30:0] m_val;
    logic        below;
    logic [30:0] x_val;
    logic [59:0] recip_prod;

    // The whole pipeline moves when the result register can take a value.
    assign advance  = !out_valid_reg || pop;
    assign req_take = advance && req_avail;

    // Offset, threshold and rounding bias after the gain multiply.
    always_comb
    begin
        rounded    = {1'b0, s1_prod_reg} + ROUND_Q16;
        m_val      = {2'b00, rounded[44:16]}
                   + {{15{cfg.offset_milli_kmh[15]}}, cfg.offset_milli_kmh};
        below      = $signed(m_val) < $signed({15'd0, cfg.zero_below_milli_kmh});
        x_val      = m_val + HALF_KMH;
        recip_prod = s2_x_reg * RECIP_1000;
    end

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= req_avail;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // Gain multiply.
            s1_kind_reg <= req.kind;
            s1_prod_reg <= req.knots_milli * cfg.gain_q16;

            // Offset and threshold.
            s2_kind_reg <= s1_kind_reg;
            s2_zero_reg <= (s1_kind_reg == KIND_SEARCH) || below;
            s2_x_reg    <= x_val[29:0];

            // Division by 1000 through the reciprocal.
            s3_kind_reg <= s2_kind_reg;
            s3_zero_reg <= s2_zero_reg;
            s3_quot_reg <= recip_prod[59:RECIP_SHIFT];

            // Saturation into the result register.
            out_kind_reg <= s3_kind_reg;
            if (s3_zero_reg)
                out_speed_reg <= 16'd0;
            else if (s3_quot_reg[20:16] != 5'd0)
                out_speed_reg <= 16'hFFFF;
            else
                out_speed_reg <= s3_quot_reg[15:0];
        end
    end

    assign empty       = !out_valid_reg;
    assign report_kind = out_kind_reg;
    assign speed_kmh   = out_speed_reg;

    // A searching report always carries a zero speed.
    a_search_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_SEARCH)) |-> (out_speed_reg == 16'd0))
        else $error("searching report with nonzero speed");

    // A waiting result that is not popped freezes the pipeline.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(s3_valid_reg)))
        else $error("pipeline moved while result was held");

endmodule
